FILE: sv/rse_pkg.sv
package rse_pkg;

  localparam int SENSOR_COUNT = 4;
  localparam int SENSOR_W     = 16;
  localparam int SEL_W        = 2;
  localparam int MINUTE_W     = 11;
  localparam int PERIOD_W     = 16;
  localparam int RULE_W       = 18;
  localparam int WINDOW_W     = 22;
  localparam int CFG_DATA_W   = 22;
  localparam int CFG_INDEX_W  = 3;
  // Elapsed seconds inside the window stay below 2^17 (1923 minutes * 60 + 63).
  localparam int ELAPSED_W    = 17;
  localparam int SECONDS_PER_MINUTE = 60;

  localparam logic [1:0] RELAY_NONE   = 2'd0;
  localparam logic [1:0] RELAY_OPEN   = 2'd1;
  localparam logic [1:0] RELAY_CLOSED = 2'd2;

  typedef enum logic [2:0] {
    MODE_MANUAL        = 3'd0,
    MODE_WINDOW        = 3'd1,
    MODE_REPEAT        = 3'd2,
    MODE_RANGE         = 3'd3,
    MODE_THRESHOLD     = 3'd4,
    MODE_THRESH_REPEAT = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    CFG_MODE          = 3'd0,
    CFG_WINDOW        = 3'd1,
    CFG_PHASE_ONE     = 3'd2,
    CFG_PHASE_TWO     = 3'd3,
    CFG_RULE_A        = 3'd4,
    CFG_RULE_B        = 3'd5,
    CFG_SENSOR_SELECT = 3'd6,
    CFG_STATE_BITS    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                                 time_valid;
    logic [4:0]                           hour;
    logic [5:0]                           minute;
    logic [5:0]                           second;
    logic [SENSOR_COUNT-1:0][SENSOR_W-1:0] sensor;
  } sample_t;

  typedef struct packed {
    logic [2:0]          mode;
    logic [MINUTE_W-1:0] win_start;
    logic [MINUTE_W-1:0] win_end;
    logic [PERIOD_W-1:0] phase_one;
    logic [PERIOD_W-1:0] period;
    logic [RULE_W-1:0]   rule_a;
    logic [RULE_W-1:0]   rule_b;
    logic [SEL_W-1:0]    sensor_select;
    logic [2:0]          state_bits;
  } cfg_t;

  // Work item that travels down the remainder chain.
  typedef struct packed {
    logic [1:0]           relay;
    logic                 bad_period;
    logic                 use_repeat;
    logic [ELAPSED_W-1:0] dividend;
    logic [PERIOD_W-1:0]  rem;
  } item_t;

  function automatic logic [1:0] bit_state(input logic b);
    return b ? RELAY_CLOSED : RELAY_OPEN;
  endfunction

endpackage

FILE: sv/rse_if.sv
interface rse_sample_if;
  import rse_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       time_valid;
  logic [4:0]                 hour;
  logic [5:0]                 minute;
  logic [5:0]                 second;
  logic signed [SENSOR_W-1:0] sensor_reading_0;
  logic signed [SENSOR_W-1:0] sensor_reading_1;
  logic signed [SENSOR_W-1:0] sensor_reading_2;
  logic signed [SENSOR_W-1:0] sensor_reading_3;

  modport source (output valid, time_valid, hour, minute, second, sensor_reading_0,
                  sensor_reading_1, sensor_reading_2, sensor_reading_3, input ready);
  modport sink (input valid, time_valid, hour, minute, second, sensor_reading_0,
                sensor_reading_1, sensor_reading_2, sensor_reading_3, output ready);
endinterface

interface rse_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] relay_state;
  logic       bad_period;

  modport source (output valid, relay_state, bad_period, input ready);
  modport sink (input valid, relay_state, bad_period, output ready);
endinterface

FILE: sv/rse_front.sv
module rse_front (
  input  rse_pkg::sample_t sample,
  input  rse_pkg::cfg_t    cfg,
  output rse_pkg::item_t   item
);
  import rse_pkg::*;

  logic [MINUTE_W-1:0]  cur_minute;
  logic                 in_window;
  logic                 sel_ok;
  logic [SENSOR_W-1:0]  reading;
  logic                 a_holds;
  logic                 b_holds;
  logic [MINUTE_W-1:0]  minute_diff;
  logic [ELAPSED_W-1:0] elapsed;
  logic                 repeat_ok;

  function automatic logic rule_holds(input logic [RULE_W-1:0] rule,
                                      input logic [SENSOR_W-1:0] value,
                                      input logic ok);
    logic lt;
    logic gt;
    lt = $signed(value) < $signed(rule[SENSOR_W-1:0]);
    gt = $signed(value) > $signed(rule[SENSOR_W-1:0]);
    return ok && (rule[16] ? lt : gt);
  endfunction

  assign cur_minute = MINUTE_W'(sample.hour * SECONDS_PER_MINUTE) + MINUTE_W'(sample.minute);
  assign in_window  = (cfg.win_start <= cur_minute) && (cur_minute <= cfg.win_end);
  assign repeat_ok  = sample.time_valid && in_window;

  assign sel_ok  = 32'(cfg.sensor_select) < SENSOR_COUNT;
  assign reading = sample.sensor[cfg.sensor_select];
  assign a_holds = rule_holds(cfg.rule_a, reading, sel_ok);
  assign b_holds = rule_holds(cfg.rule_b, reading, sel_ok);

  assign minute_diff = cur_minute - cfg.win_start;
  assign elapsed     = ELAPSED_W'(minute_diff * SECONDS_PER_MINUTE) + ELAPSED_W'(sample.second);

  always_comb begin
    item.relay      = RELAY_NONE;
    item.bad_period = 1'b0;
    item.use_repeat = 1'b0;
    item.dividend   = elapsed;
    item.rem        = '0;
    case (cfg.mode)
      MODE_MANUAL: begin
        item.relay = bit_state(cfg.state_bits[0]);
      end
      MODE_WINDOW: begin
        if (repeat_ok) begin
          item.relay = bit_state(cfg.state_bits[0]);
        end
      end
      MODE_REPEAT, MODE_THRESH_REPEAT: begin
        // In the gated form the first rule only opens the gate; its target is unused.
        if (repeat_ok && (cfg.mode == MODE_REPEAT || a_holds)) begin
          if (cfg.period == '0) begin
            item.bad_period = 1'b1;
          end else begin
            item.use_repeat = 1'b1;
          end
        end
      end
      MODE_RANGE: begin
        if (a_holds) begin
          item.relay = bit_state(cfg.rule_a[17]);
        end else if (b_holds) begin
          item.relay = bit_state(cfg.rule_b[17]);
        end
      end
      MODE_THRESHOLD: begin
        if (a_holds) begin
          item.relay = bit_state(cfg.rule_a[17]);
        end
      end
      default: begin
        item.relay = RELAY_NONE;
      end
    endcase
  end

endmodule

FILE: sv/rse_mod_cell.sv
module rse_mod_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rse_pkg::PERIOD_W-1:0]     period,
  input  logic                             prev_valid,
  input  rse_pkg::item_t                   prev_item,
  output logic                             take,
  input  logic                             next_take,
  output logic                             valid,
  output rse_pkg::item_t                   item
);
  import rse_pkg::*;

  logic [PERIOD_W:0] shifted;
  logic [PERIOD_W:0] reduced;
  item_t             item_next;

  // The cell loads whenever it is empty or its content moves on.
  assign take = !valid || next_take;

  // One restoring step: bring in the next dividend bit, subtract the period if it fits.
  assign shifted = {prev_item.rem, prev_item.dividend[ELAPSED_W-1]};
  assign reduced = (shifted >= {1'b0, period}) ? shifted - {1'b0, period} : shifted;

  always_comb begin
    item_next          = prev_item;
    item_next.rem      = reduced[PERIOD_W-1:0];
    item_next.dividend = {prev_item.dividend[ELAPSED_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

endmodule

FILE: sv/relay_schedule_evaluator.sv
// Relay schedule evaluator.
// The sample channel carries one time of day with its valid flag and four sensor
// readings per transaction; the result channel returns one relay state and a
// bad-period flag for every sample, in order. Both use valid/ready handshakes.
// Rules are set through the write port (cfg_we, cfg_index, cfg_data) while no
// sample is in flight.
// The sample is decoded as it enters the first cell, and the elapsed seconds are
// reduced modulo the repeat period in a chain of 17 remainder cells, one dividend
// bit per cell, followed by the output register. One sample is accepted every
// cycle while the chain has room, that is while sample ready is high.
// Every stage advances when it is empty or when its successor moves, so bubbles
// collapse and the block keeps accepting samples while a result waits. When the
// receiver stalls, the chain fills and sample ready falls only once all 18 stages
// hold data. Reset empties the chain and clears every rule register to zero.
module relay_schedule_evaluator (
  input  logic                             clk,
  input  logic                             rst,
  rse_sample_if.sink                       sample,
  rse_result_if.source                     result,
  input  logic                             cfg_we,
  input  logic [rse_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rse_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rse_pkg::*;

  localparam int CELLS = ELAPSED_W;

  logic [2:0]          mode;
  logic [WINDOW_W-1:0] window_minutes;
  logic [PERIOD_W-1:0] phase_one_seconds;
  logic [PERIOD_W-1:0] phase_two_seconds;
  logic [RULE_W-1:0]   rule_a;
  logic [RULE_W-1:0]   rule_b;
  logic [SEL_W-1:0]    sensor_select;
  logic [2:0]          state_bits;

  cfg_t    cfg;
  sample_t sample_data;
  item_t   front_item;

  logic  cell_valid [CELLS];
  item_t cell_item  [CELLS];
  logic  cell_take  [CELLS+1];

  logic       out_valid;
  logic [1:0] relay_state;
  logic       bad_period;
  logic [1:0] relay_next;
  item_t      last_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= '0;
      window_minutes    <= '0;
      phase_one_seconds <= '0;
      phase_two_seconds <= '0;
      rule_a            <= '0;
      rule_b            <= '0;
      sensor_select     <= '0;
      state_bits        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:          mode              <= cfg_data[2:0];
        CFG_WINDOW:        window_minutes    <= cfg_data[WINDOW_W-1:0];
        CFG_PHASE_ONE:     phase_one_seconds <= cfg_data[PERIOD_W-1:0];
        CFG_PHASE_TWO:     phase_two_seconds <= cfg_data[PERIOD_W-1:0];
        CFG_RULE_A:        rule_a            <= cfg_data[RULE_W-1:0];
        CFG_RULE_B:        rule_b            <= cfg_data[RULE_W-1:0];
        CFG_SENSOR_SELECT: sensor_select     <= cfg_data[SEL_W-1:0];
        CFG_STATE_BITS:    state_bits        <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.mode          = mode;
    cfg.win_start     = window_minutes[2*MINUTE_W-1:MINUTE_W];
    cfg.win_end       = window_minutes[MINUTE_W-1:0];
    cfg.phase_one     = phase_one_seconds;
    cfg.period        = phase_one_seconds + phase_two_seconds;
    cfg.rule_a        = rule_a;
    cfg.rule_b        = rule_b;
    cfg.sensor_select = sensor_select;
    cfg.state_bits    = state_bits;
  end

  always_comb begin
    sample_data.time_valid = sample.time_valid;
    sample_data.hour       = sample.hour;
    sample_data.minute     = sample.minute;
    sample_data.second     = sample.second;
    sample_data.sensor[0]  = sample.sensor_reading_0;
    sample_data.sensor[1]  = sample.sensor_reading_1;
    sample_data.sensor[2]  = sample.sensor_reading_2;
    sample_data.sensor[3]  = sample.sensor_reading_3;
  end

  rse_front u_front (
    .sample (sample_data),
    .cfg    (cfg),
    .item   (front_item)
  );

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    if (i == 0) begin : g_first
      rse_mod_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .period     (cfg.period),
        .prev_valid (sample.valid),
        .prev_item  (front_item),
        .take       (cell_take[0]),
        .next_take  (cell_take[1]),
        .valid      (cell_valid[0]),
        .item       (cell_item[0])
      );
    end else begin : g_rest
      rse_mod_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .period     (cfg.period),
        .prev_valid (cell_valid[i-1]),
        .prev_item  (cell_item[i-1]),
        .take       (cell_take[i]),
        .next_take  (cell_take[i+1]),
        .valid      (cell_valid[i]),
        .item       (cell_item[i])
      );
    end
  end

  assign sample.ready     = cell_take[0];
  assign cell_take[CELLS] = !out_valid || result.ready;

  assign last_item = cell_item[CELLS-1];

  always_comb begin
    relay_next = last_item.relay;
    if (last_item.use_repeat) begin
      relay_next = (last_item.rem < phase_one_seconds) ? bit_state(state_bits[1])
                                                      : bit_state(state_bits[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cell_take[CELLS]) begin
      out_valid <= cell_valid[CELLS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cell_take[CELLS]) begin
      relay_state <= relay_next;
      bad_period  <= last_item.bad_period;
    end
  end

  assign result.valid       = out_valid;
  assign result.relay_state = relay_state;
  assign result.bad_period  = bad_period;

  // A zero period never comes with a decision.
  a_bad_is_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_period |-> relay_state == RELAY_NONE)
    else $error("bad period flagged with a relay decision");

  // Only the three defined relay codes leave the block.
  a_relay_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> relay_state != 2'd3)
    else $error("undefined relay code on result");

  // Sample ready falls only when the whole chain is full behind a stalled receiver.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> out_valid && !result.ready && cell_valid[0] && cell_valid[CELLS-1])
    else $error("sample ready low with room in the chain");

  // A repeat item always carries a nonzero period and no bad flag.
  a_repeat_period: assert property (@(posedge clk) disable iff (rst)
    cell_valid[CELLS-1] && last_item.use_repeat |-> !last_item.bad_period && cfg.period != '0)
    else $error("repeat item with a zero period");

  // The chain is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !cell_valid[0])
    else $error("chain not empty after reset");

endmodule

FILE: test/relay_state_checker.sv
`timescale 1ns / 1ps

module relay_state_checker (
  input  logic                            clk,
  input  logic                            rst,
  rse_sample_if                           sample,
  rse_result_if                           result,
  input  logic                            cfg_we,
  input  logic [rse_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rse_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              outstanding
);
  import rse_pkg::*;

  localparam int MINUTES_PER_HOUR = 60;

  typedef struct packed {
    logic [2:0]          mode;
    logic [MINUTE_W-1:0] win_start;
    logic [MINUTE_W-1:0] win_end;
    logic [PERIOD_W-1:0] phase_one;
    logic [PERIOD_W-1:0] phase_two;
    logic [RULE_W-1:0]   rule_a;
    logic [RULE_W-1:0]   rule_b;
    logic [SEL_W-1:0]    sel;
    logic [2:0]          state_bits;
  } relay_rules_t;

  typedef struct packed {
    logic [1:0] relay;
    logic       bad_period;
  } relay_verdict_t;

  relay_rules_t   rules;
  relay_verdict_t expected_relay_q[$];

  function automatic logic [1:0] relay_for(input logic closed);
    return closed ? RELAY_CLOSED : RELAY_OPEN;
  endfunction

  function automatic int minute_of_day(input sample_t s);
    return int'(s.hour) * MINUTES_PER_HOUR + int'(s.minute);
  endfunction

  function automatic logic within_window(input int cur);
    return (int'(rules.win_start) <= cur) && (cur <= int'(rules.win_end));
  endfunction

  // Strict signed comparison of the selected reading against the rule threshold.
  function automatic logic rule_passes(input logic [RULE_W-1:0] rule, input sample_t s);
    logic signed [SENSOR_W-1:0] reading;
    logic signed [SENSOR_W-1:0] limit;
    if (int'(rules.sel) >= SENSOR_COUNT) return 1'b0;
    reading = s.sensor[rules.sel];
    limit   = rule[SENSOR_W-1:0];
    return rule[SENSOR_W] ? (reading < limit) : (reading > limit);
  endfunction

  function automatic logic [1:0] rule_target(input logic [RULE_W-1:0] rule,
                                             input sample_t s);
    if (!rule_passes(rule, s)) return RELAY_NONE;
    return relay_for(rule[SENSOR_W+1]);
  endfunction

  function automatic relay_verdict_t duty_cycle(input sample_t s);
    relay_verdict_t v;
    int cur;
    int period;
    int elapsed;
    v.relay      = RELAY_NONE;
    v.bad_period = 1'b0;
    cur = minute_of_day(s);
    if (!s.time_valid || !within_window(cur)) return v;
    period = (int'(rules.phase_one) + int'(rules.phase_two)) % (1 << PERIOD_W);
    if (period == 0) begin
      v.bad_period = 1'b1;
      return v;
    end
    elapsed = (cur - int'(rules.win_start)) * SECONDS_PER_MINUTE + int'(s.second);
    if ((elapsed % period) < int'(rules.phase_one)) begin
      v.relay = relay_for(rules.state_bits[1]);
    end else begin
      v.relay = relay_for(rules.state_bits[2]);
    end
    return v;
  endfunction

  function automatic relay_verdict_t predict_relay(input sample_t s);
    relay_verdict_t v;
    v.relay      = RELAY_NONE;
    v.bad_period = 1'b0;
    case (rules.mode)
      MODE_MANUAL: v.relay = relay_for(rules.state_bits[0]);
      MODE_WINDOW: begin
        if (s.time_valid && within_window(minute_of_day(s)))
          v.relay = relay_for(rules.state_bits[0]);
      end
      MODE_REPEAT: v = duty_cycle(s);
      MODE_RANGE: begin
        v.relay = rule_target(rules.rule_a, s);
        if (v.relay == RELAY_NONE) v.relay = rule_target(rules.rule_b, s);
      end
      MODE_THRESHOLD: v.relay = rule_target(rules.rule_a, s);
      MODE_THRESH_REPEAT: begin
        // Only the comparison of the first rule gates here; its target is unused.
        if (rule_passes(rules.rule_a, s)) v = duty_cycle(s);
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic sample_t sample_now();
    sample_t s;
    s.time_valid = sample.time_valid;
    s.hour       = sample.hour;
    s.minute     = sample.minute;
    s.second     = sample.second;
    s.sensor[0]  = sample.sensor_reading_0;
    s.sensor[1]  = sample.sensor_reading_1;
    s.sensor[2]  = sample.sensor_reading_2;
    s.sensor[3]  = sample.sensor_reading_3;
    return s;
  endfunction

  always @(posedge clk) begin : track
    relay_verdict_t want;
    int errs;
    errs = 0;
    if (rst) begin
      rules <= '0;
      expected_relay_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:          rules.mode <= cfg_data[2:0];
          CFG_WINDOW: begin
            rules.win_start <= cfg_data[2*MINUTE_W-1:MINUTE_W];
            rules.win_end   <= cfg_data[MINUTE_W-1:0];
          end
          CFG_PHASE_ONE:     rules.phase_one <= cfg_data[PERIOD_W-1:0];
          CFG_PHASE_TWO:     rules.phase_two <= cfg_data[PERIOD_W-1:0];
          CFG_RULE_A:        rules.rule_a <= cfg_data[RULE_W-1:0];
          CFG_RULE_B:        rules.rule_b <= cfg_data[RULE_W-1:0];
          CFG_SENSOR_SELECT: rules.sel <= cfg_data[SEL_W-1:0];
          CFG_STATE_BITS:    rules.state_bits <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (expected_relay_q.size() == 0) begin
          $error("relay_state %0d, bad_period %0d arrived with no sample outstanding",
                 result.relay_state, result.bad_period);
          errs++;
        end else begin
          want = expected_relay_q.pop_front();
          if (result.relay_state !== want.relay) begin
            $error("relay_state: expected %0d, got %0d", want.relay, result.relay_state);
            errs++;
          end
          if (result.bad_period !== want.bad_period) begin
            $error("bad_period: expected %0d, got %0d", want.bad_period, result.bad_period);
            errs++;
          end
        end
      end
      if (sample.valid && sample.ready) expected_relay_q.push_back(predict_relay(sample_now()));
      outstanding <= expected_relay_q.size();
      fail_count  <= fail_count + errs;
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rse_pkg::*;

  localparam logic [2:0] MODE_RESERVED_LO = 3'd6;
  localparam logic [2:0] MODE_RESERVED_HI = 3'd7;
  localparam logic       TARGET_OPEN      = 1'b0;
  localparam logic       TARGET_CLOSED    = 1'b1;
  localparam logic       OP_GREATER       = 1'b0;
  localparam logic       OP_LESS          = 1'b1;
  localparam int MAX_MINUTE    = 31 * 60 + 63;
  localparam int WINDOW_FULL   = (1 << MINUTE_W) - 1;
  localparam int RANDOM_PHASES = 40;
  localparam int HOLD_PHASE    = 3;
  localparam int LONG_HOLD     = 160;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;

  typedef enum {ALWAYS_READY, COIN_FLIP, MOSTLY_READY, MOSTLY_STALLED, EVERY_THIRD}
    stall_style_t;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int fail_count;
  int outstanding;
  int hold_requests = 0;

  // Copy of the window and thresholds, used only to aim the random samples.
  int          win_lo;
  int          win_hi;
  logic [15:0] thr_a;
  logic [15:0] thr_b;

  rse_sample_if sample_ch ();
  rse_result_if result_ch ();

  relay_schedule_evaluator dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  relay_state_checker state_check (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample_ch),
    .result      (result_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_rules(input logic [2:0] mode, input int lo, input int hi,
                            input logic [15:0] p1, input logic [15:0] p2,
                            input logic [RULE_W-1:0] ra, input logic [RULE_W-1:0] rb,
                            input logic [1:0] sel, input logic [2:0] sb);
    win_lo = lo;
    win_hi = hi;
    thr_a  = ra[15:0];
    thr_b  = rb[15:0];
    put_reg(CFG_MODE, CFG_DATA_W'(mode));
    put_reg(CFG_WINDOW, {11'(lo), 11'(hi)});
    put_reg(CFG_PHASE_ONE, CFG_DATA_W'(p1));
    put_reg(CFG_PHASE_TWO, CFG_DATA_W'(p2));
    put_reg(CFG_RULE_A, CFG_DATA_W'(ra));
    put_reg(CFG_RULE_B, CFG_DATA_W'(rb));
    put_reg(CFG_SENSOR_SELECT, CFG_DATA_W'(sel));
    put_reg(CFG_STATE_BITS, CFG_DATA_W'(sb));
    cfg_we <= 1'b0;
  endtask

  task automatic offer(input sample_t s);
    sample_ch.valid            <= 1'b1;
    sample_ch.time_valid       <= s.time_valid;
    sample_ch.hour             <= s.hour;
    sample_ch.minute           <= s.minute;
    sample_ch.second           <= s.second;
    sample_ch.sensor_reading_0 <= s.sensor[0];
    sample_ch.sensor_reading_1 <= s.sensor[1];
    sample_ch.sensor_reading_2 <= s.sensor[2];
    sample_ch.sensor_reading_3 <= s.sensor[3];
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // Stops offering and waits until every result has been taken.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // The chosen reading gets r, the other sensors its complement.
  function automatic sample_t probe(input logic tv, input logic [4:0] h, input logic [5:0] m,
                                    input logic [5:0] sec, input int idx,
                                    input logic [15:0] r);
    sample_t s;
    s.time_valid = tv;
    s.hour       = h;
    s.minute     = m;
    s.second     = sec;
    for (int i = 0; i < SENSOR_COUNT; i++) s.sensor[i] = (i == idx) ? r : ~r;
    return s;
  endfunction

  function automatic logic [15:0] random_reading();
    logic [15:0] thr;
    thr = $urandom_range(0, 1) ? thr_a : thr_b;
    case ($urandom_range(0, 6))
      0: return thr;
      1: return thr + 16'd1;
      2: return thr - 16'd1;
      3: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int cur;
    int top;
    int h;
    top = (win_hi < MAX_MINUTE) ? win_hi : MAX_MINUTE;
    s.time_valid = ($urandom_range(0, 9) != 0);
    if (win_lo <= top && $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 7))
        0: cur = win_lo;
        1: cur = top;
        2: cur = (win_lo > 0) ? win_lo - 1 : win_lo;
        3: cur = (top < MAX_MINUTE) ? top + 1 : top;
        default: cur = $urandom_range(top, win_lo);
      endcase
      h = (cur / 60 > 31) ? 31 : cur / 60;
      s.hour   = 5'(h);
      s.minute = 6'(cur - h * 60);
    end else begin
      s.hour   = 5'($urandom_range(0, 31));
      s.minute = 6'($urandom_range(0, 63));
    end
    s.second = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(60, 63))
                                            : 6'($urandom_range(0, 59));
    for (int i = 0; i < SENSOR_COUNT; i++) s.sensor[i] = random_reading();
    return s;
  endfunction

  function automatic logic [RULE_W-1:0] random_rule();
    logic [15:0] thr;
    case ($urandom_range(0, 5))
      0: thr = 16'h8000;
      1: thr = 16'h7FFF;
      default: thr = 16'($urandom);
    endcase
    return {1'($urandom), 1'($urandom), thr};
  endfunction

  task automatic random_rules();
    logic [2:0]  mode;
    logic [15:0] p1;
    logic [15:0] p2;
    int lo;
    int hi;
    case ($urandom_range(0, 11))
      0: mode = 3'($urandom_range(MODE_RESERVED_HI, MODE_RESERVED_LO));
      1, 2, 3: mode = MODE_REPEAT;
      4, 5, 6: mode = MODE_THRESH_REPEAT;
      default: mode = 3'($urandom_range(MODE_THRESH_REPEAT, MODE_MANUAL));
    endcase
    case ($urandom_range(0, 5))
      0: begin
        lo = 0;
        hi = WINDOW_FULL;
      end
      1: begin
        lo = $urandom_range(0, WINDOW_FULL);
        hi = $urandom_range(0, WINDOW_FULL);
      end
      default: begin
        lo = $urandom_range(0, 1800);
        hi = lo + $urandom_range(0, 150);
      end
    endcase
    case ($urandom_range(0, 7))
      0: begin
        p1 = 16'd0;
        p2 = 16'd0;
      end
      1: begin
        // The two phases add up to a full 16-bit wrap.
        p1 = 16'($urandom);
        p2 = -p1;
      end
      2: begin
        p1 = 16'($urandom);
        p2 = 16'($urandom);
      end
      3: begin
        p1 = 16'hFFFF;
        p2 = 16'($urandom_range(1, 64));
      end
      default: begin
        p1 = 16'($urandom_range(0, 40));
        p2 = 16'($urandom_range(0, 40));
      end
    endcase
    load_rules(mode, lo, hi, p1, p2, random_rule(), random_rule(),
               2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
  endtask

  task automatic send_batch(input int count, input bit back_to_back);
    int burst_left;
    burst_left = $urandom_range(1, 24);
    for (int k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (!back_to_back) begin
          sample_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
      offer(random_sample());
      burst_left--;
    end
  endtask

  initial begin : result_sink
    stall_style_t style;
    int style_left;
    int hold_left;
    int holds_served;
    style        = ALWAYS_READY;
    style_left   = 0;
    hold_left    = 0;
    holds_served = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (style_left == 0) begin
        style      = stall_style_t'($urandom_range(0, 4));
        style_left = $urandom_range(32, 256);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        case (style)
          ALWAYS_READY:   result_ch.ready <= 1'b1;
          COIN_FLIP:      result_ch.ready <= 1'($urandom);
          MOSTLY_READY:   result_ch.ready <= ($urandom_range(0, 9) != 0);
          MOSTLY_STALLED: result_ch.ready <= ($urandom_range(0, 4) == 0);
          default:        result_ch.ready <= (style_left % 3 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL relay_schedule_evaluator");
    $finish;
  end

  initial begin : stimulus
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_MODE;
    cfg_data  <= '0;
    sample_ch.valid            <= 1'b0;
    sample_ch.time_valid       <= 1'b0;
    sample_ch.hour             <= '0;
    sample_ch.minute           <= '0;
    sample_ch.second           <= '0;
    sample_ch.sensor_reading_0 <= '0;
    sample_ch.sensor_reading_1 <= '0;
    sample_ch.sensor_reading_2 <= '0;
    sample_ch.sensor_reading_3 <= '0;
    win_lo = 0;
    win_hi = 0;
    thr_a  = '0;
    thr_b  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Manual state with out-of-range time fields and extreme readings.
    load_rules(MODE_MANUAL, 0, 0, 16'd0, 16'd0, '0, '0, 2'd0, 3'b000);
    offer(probe(1'b0, 5'd31, 6'd63, 6'd63, 0, 16'h8000));
    drain();
    load_rules(MODE_MANUAL, 0, 0, 16'd0, 16'd0, '0, '0, 2'd0, 3'b111);
    offer(probe(1'b1, 5'd0, 6'd0, 6'd0, 3, 16'h7FFF));
    drain();

    // Single-shot window: both inclusive edges, one minute early, invalid time.
    load_rules(MODE_WINDOW, 60, MAX_MINUTE, 16'd0, 16'd0, '0, '0, 2'd0, 3'b001);
    offer(probe(1'b1, 5'd1, 6'd0, 6'd0, 0, 16'h0000));
    offer(probe(1'b1, 5'd0, 6'd59, 6'd0, 0, 16'h0000));
    offer(probe(1'b0, 5'd5, 6'd0, 6'd0, 0, 16'h0000));
    offer(probe(1'b1, 5'd31, 6'd63, 6'd63, 0, 16'h0000));
    drain();

    // Phases that wrap to a zero period.
    load_rules(MODE_REPEAT, 0, WINDOW_FULL, 16'hFFFF, 16'h0001, '0, '0, 2'd0, 3'b110);
    offer(probe(1'b1, 5'd0, 6'd0, 6'd0, 0, 16'h0000));
    offer(probe(1'b0, 5'd0, 6'd0, 6'd0, 0, 16'h0000));
    drain();

    // Phase boundaries of a 15 second period starting at 2:00.
    load_rules(MODE_REPEAT, 120, 180, 16'd10, 16'd5, '0, '0, 2'd0, 3'b100);
    offer(probe(1'b1, 5'd2, 6'd0, 6'd9, 0, 16'h0000));
    offer(probe(1'b1, 5'd2, 6'd0, 6'd10, 0, 16'h0000));
    offer(probe(1'b1, 5'd2, 6'd0, 6'd15, 0, 16'h0000));
    offer(probe(1'b1, 5'd3, 6'd0, 6'd63, 0, 16'h0000));
    drain();

    // A period that wraps down to one second.
    load_rules(MODE_REPEAT, 0, WINDOW_FULL, 16'hFFFF, 16'h0002, '0, '0, 2'd0, 3'b010);
    offer(probe(1'b1, 5'd23, 6'd59, 6'd59, 0, 16'h0000));
    drain();

    // Range: first rule holds, equal reading fails both, second rule holds.
    load_rules(MODE_RANGE, 0, 0, 16'd0, 16'd0, {TARGET_CLOSED, OP_GREATER, 16'h0100},
               {TARGET_OPEN, OP_LESS, 16'hFF00}, 2'd2, 3'b000);
    offer(probe(1'b1, 5'd0, 6'd0, 6'd0, 2, 16'h0101));
    offer(probe(1'b1, 5'd0, 6'd0, 6'd0, 2, 16'h0100));
    offer(probe(1'b1, 5'd0, 6'd0, 6'd0, 2, 16'h8000));
    drain();

    load_rules(MODE_THRESHOLD, 0, 0, 16'd0, 16'd0, {TARGET_OPEN, OP_LESS, 16'h7FFF}, '0,
               2'd3, 3'b000);
    offer(probe(1'b1, 5'd0, 6'd0, 6'd0, 3, 16'h7FFE));
    offer(probe(1'b1, 5'd0, 6'd0, 6'd0, 3, 16'h7FFF));
    drain();

    // Gate open, gate closed, then the second phase.
    load_rules(MODE_THRESH_REPEAT, 0, WINDOW_FULL, 16'd1, 16'd1,
               {TARGET_OPEN, OP_GREATER, 16'hFFFF}, '0, 2'd0, 3'b010);
    offer(probe(1'b1, 5'd0, 6'd0, 6'd0, 0, 16'h0000));
    offer(probe(1'b1, 5'd0, 6'd0, 6'd0, 0, 16'hFFFF));
    offer(probe(1'b1, 5'd0, 6'd0, 6'd1, 0, 16'h7FFF));
    drain();

    load_rules(MODE_RESERVED_LO, 0, WINDOW_FULL, 16'd1, 16'd1, '0, '0, 2'd1, 3'b111);
    offer(probe(1'b1, 5'd0, 6'd0, 6'd0, 1, 16'h0000));
    drain();
    load_rules(MODE_RESERVED_HI, 0, WINDOW_FULL, 16'd1, 16'd1, '0, '0, 2'd1, 3'b111);
    offer(probe(1'b1, 5'd0, 6'd0, 6'd0, 1, 16'h0000));
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_rules();
      if (phase == HOLD_PHASE) begin
        // The receiver stalls long enough for the whole pipeline to back up.
        hold_requests <= hold_requests + 1;
        send_batch(60, 1'b1);
      end else begin
        send_batch($urandom_range(20, 64), ($urandom_range(0, 3) == 0));
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS relay_schedule_evaluator");
    end else begin
      $display("FAIL relay_schedule_evaluator");
    end
    $finish;
  end

endmodule
